FILE: hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the GPIO register block checkers.
// The checker that uses them names its clock i_clk and its reset i_rst_n.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gpio_pkg.sv
// -----------------------------------------------------------------------------
// GPIO package
// Sizes, register word addresses and field codes of the GPIO register block.
// -----------------------------------------------------------------------------
package gpio_pkg;

    // Number of pins in the bank (1 to 64).
    localparam int NUM_PINS = 54;

    // Function select words: 3 bits per pin, 10 pins per word.
    localparam int FSEL_WORDS = 7;
    localparam int FSEL_BITS  = 3;
    localparam int FSEL_SLOTS = 10;

    // Request packing on the input stream.
    localparam int IN_BITS     = 6 + 32 + NUM_PINS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // Result packing on the output stream.
    localparam int OUT_DRV_LSB = 32;
    localparam int OUT_OE_LSB  = OUT_DRV_LSB + NUM_PINS;
    localparam int OUT_PU_LSB  = OUT_OE_LSB + NUM_PINS;
    localparam int OUT_PD_LSB  = OUT_PU_LSB + NUM_PINS;
    localparam int OUT_BITS    = OUT_PD_LSB + NUM_PINS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Register word addresses (byte offset divided by four).
    localparam logic [5:0] ADDR_SET0    = 6'd7;
    localparam logic [5:0] ADDR_CLR0    = 6'd10;
    localparam logic [5:0] ADDR_LEV0    = 6'd13;
    localparam logic [5:0] ADDR_LEV1    = 6'd14;
    localparam logic [5:0] ADDR_PUD     = 6'd37;
    localparam logic [5:0] ADDR_PUDCLK0 = 6'd38;

    // Access kinds.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Field codes.
    localparam logic [2:0] FSEL_OUTPUT = 3'b001;
    localparam logic [1:0] PULL_DOWN   = 2'b01;
    localparam logic [1:0] PULL_UP     = 2'b10;

    typedef logic [FSEL_BITS-1:0] t_fsel;
    typedef logic [1:0]           t_pull;
    typedef logic [NUM_PINS-1:0]  t_pins;

endpackage

FILE: hw/rtl/gpio_register_block_unit.sv
// Flow: a request accepted into the input register moves on into the result
// register when the pipeline advances, and its result is then on the output.
// Throughput: one request per cycle; the input register and the result register
// form a two-stage pipeline that advances whenever the result register is free
// or being taken.
// Reset: synchronous, active low; all pins become inputs, drive latches and pull
// settings clear, and both pipeline registers empty.
// -----------------------------------------------------------------------------
// GPIO register block unit
// Word-addressed GPIO controller: function select, set, clear, level and pull
// registers, one bus access per stream request.
// -----------------------------------------------------------------------------
module gpio_register_block_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // From bit 0: word_address[5:0], write_data[31:0], pin_levels, zero pad.
    input  logic [gpio_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // From bit 0: command.
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // From bit 0: read_data[31:0], pin_drive, pin_output_enable, pin_pull_up,
    // pin_pull_down, zero pad.
    output logic [gpio_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // Input register.
    logic                  r_in_valid;
    logic                  r_cmd;
    logic [5:0]            r_addr;
    logic [31:0]           r_wdata;
    gpio_pkg::t_pins       r_levels;

    // Block state.
    gpio_pkg::t_fsel       r_fsel [gpio_pkg::NUM_PINS];
    gpio_pkg::t_pull       r_pull [gpio_pkg::NUM_PINS];
    gpio_pkg::t_pins       r_drive;
    gpio_pkg::t_pull       r_pull_ctl;

    gpio_pkg::t_fsel       n_fsel [gpio_pkg::NUM_PINS];
    gpio_pkg::t_pull       n_pull [gpio_pkg::NUM_PINS];
    gpio_pkg::t_pins       n_drive;
    gpio_pkg::t_pull       n_pull_ctl;

    // Result register.
    logic                  r_out_valid;
    logic [31:0]           r_rdata;
    gpio_pkg::t_pins       r_out_drv;
    gpio_pkg::t_pins       r_out_oe;
    gpio_pkg::t_pins       r_out_pu;
    gpio_pkg::t_pins       r_out_pd;

    logic [31:0]           n_rdata;
    gpio_pkg::t_pins       n_oe;
    gpio_pkg::t_pins       n_pu;
    gpio_pkg::t_pins       n_pd;

    logic                  w_adv;
    logic                  w_wr;
    logic [31:0]           w_fsel_word [gpio_pkg::FSEL_WORDS];
    gpio_pkg::t_pins       w_oe_cur;
    logic [63:0]           w_lev64;

    // The pipeline advances when the result register is empty or being taken.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_wr          = r_in_valid && w_adv && (r_cmd == gpio_pkg::CMD_WRITE);

    // Input register load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd    <= s_axis_tuser;
            r_addr   <= s_axis_tdata[5:0];
            r_wdata  <= s_axis_tdata[37:6];
            r_levels <= s_axis_tdata[38 +: gpio_pkg::NUM_PINS];
        end
    end

    // Write decode: pull control word, and per-pin function select, set, clear and pull clock words.
    always_comb begin
        n_drive    = r_drive;
        n_pull_ctl = r_pull_ctl;
        if (w_wr && (r_addr == gpio_pkg::ADDR_PUD)) begin
            n_pull_ctl = r_wdata[1:0];
        end
        for (int p = 0; p < gpio_pkg::NUM_PINS; p++) begin
            n_fsel[p] = r_fsel[p];
            n_pull[p] = r_pull[p];
            if (w_wr && (r_addr == 6'(p / 10))) begin
                n_fsel[p] = r_wdata[gpio_pkg::FSEL_BITS * (p % 10) +: gpio_pkg::FSEL_BITS];
            end
            if (w_wr && (r_addr == gpio_pkg::ADDR_SET0 + 6'(p / 32)) && r_wdata[p % 32]) begin
                n_drive[p] = 1'b1;
            end
            if (w_wr && (r_addr == gpio_pkg::ADDR_CLR0 + 6'(p / 32)) && r_wdata[p % 32]) begin
                n_drive[p] = 1'b0;
            end
            if (w_wr && (r_addr == gpio_pkg::ADDR_PUDCLK0 + 6'(p / 32))
                    && r_wdata[p % 32]) begin
                n_pull[p] = r_pull_ctl;
            end
        end
    end

    // Pin-side views of the current and the updated state.
    always_comb begin
        for (int w = 0; w < gpio_pkg::FSEL_WORDS; w++) begin
            w_fsel_word[w] = '0;
        end
        for (int p = 0; p < gpio_pkg::NUM_PINS; p++) begin
            w_fsel_word[p / 10][gpio_pkg::FSEL_BITS * (p % 10) +: gpio_pkg::FSEL_BITS] =
                r_fsel[p];
            w_oe_cur[p] = (r_fsel[p] == gpio_pkg::FSEL_OUTPUT);
            n_oe[p]     = (n_fsel[p] == gpio_pkg::FSEL_OUTPUT);
            n_pu[p]     = (n_pull[p] == gpio_pkg::PULL_UP);
            n_pd[p]     = (n_pull[p] == gpio_pkg::PULL_DOWN);
        end
    end

    // Output pins read their latch, all other pins their external level.
    assign w_lev64 = 64'((r_drive & w_oe_cur) | (r_levels & ~w_oe_cur));

    // Read data mux; writes return zero.
    always_comb begin
        n_rdata = '0;
        if (r_cmd == gpio_pkg::CMD_READ) begin
            case (r_addr)
                gpio_pkg::ADDR_LEV0: n_rdata = w_lev64[31:0];
                gpio_pkg::ADDR_LEV1: n_rdata = w_lev64[63:32];
                gpio_pkg::ADDR_PUD:  n_rdata = {30'd0, r_pull_ctl};
                default: begin
                    if (r_addr < 6'(gpio_pkg::FSEL_WORDS)) begin
                        n_rdata = w_fsel_word[r_addr[2:0]];
                    end
                end
            endcase
        end
    end

    // State update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive    <= '0;
            r_pull_ctl <= '0;
            for (int p = 0; p < gpio_pkg::NUM_PINS; p++) begin
                r_fsel[p] <= '0;
                r_pull[p] <= '0;
            end
        end else if (w_wr) begin
            r_drive    <= n_drive;
            r_pull_ctl <= n_pull_ctl;
            for (int p = 0; p < gpio_pkg::NUM_PINS; p++) begin
                r_fsel[p] <= n_fsel[p];
                r_pull[p] <= n_pull[p];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_adv) begin
            r_rdata   <= n_rdata;
            r_out_drv <= n_drive;
            r_out_oe  <= n_oe;
            r_out_pu  <= n_pu;
            r_out_pd  <= n_pd;
        end
    end

    // Result packing.
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[31:0] = r_rdata;
        m_axis_tdata[gpio_pkg::OUT_DRV_LSB +: gpio_pkg::NUM_PINS] = r_out_drv;
        m_axis_tdata[gpio_pkg::OUT_OE_LSB +: gpio_pkg::NUM_PINS]  = r_out_oe;
        m_axis_tdata[gpio_pkg::OUT_PU_LSB +: gpio_pkg::NUM_PINS]  = r_out_pu;
        m_axis_tdata[gpio_pkg::OUT_PD_LSB +: gpio_pkg::NUM_PINS]  = r_out_pd;
    end

endmodule

FILE: hw/rtl/gpio_chk.sv
// -----------------------------------------------------------------------------
// GPIO checker
// Port-level assertions for the GPIO register block, bound to the register block module.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpio_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tready,
    input logic                                i_m_tvalid,
    input logic                                i_m_tready,
    input logic [gpio_pkg::OUT_TDATA_W-1:0]    i_m_tdata
);

    logic [gpio_pkg::NUM_PINS-1:0] w_pu;
    logic [gpio_pkg::NUM_PINS-1:0] w_pd;
    logic                          w_stall;
    logic                          w_pull_both;

    assign w_pu        = i_m_tdata[gpio_pkg::OUT_PU_LSB +: gpio_pkg::NUM_PINS];
    assign w_pd        = i_m_tdata[gpio_pkg::OUT_PD_LSB +: gpio_pkg::NUM_PINS];
    assign w_stall     = i_m_tvalid && !i_m_tready;
    assign w_pull_both = |(w_pu & w_pd);

    // A stalled result stays put.
    `ASSERT_CLK(a_out_hold, w_stall |=> i_m_tvalid && $stable(i_m_tdata), "stalled result changed")

    // An empty result register never blocks a new request.
    `ASSERT_CLK(a_ready_when_empty, !i_m_tvalid |-> i_s_tready, "input stalled with empty output")

    // A pin never has both pull resistors enabled.
    `ASSERT_CLK(a_pull_exclusive, i_m_tvalid |-> !w_pull_both, "pull-up and pull-down both on")

    // Reset empties the result register.
    `ASSERT_CLK_ALWAYS(a_reset_empty, !i_rst_n |=> !i_m_tvalid, "result valid after reset")

endmodule

bind gpio_register_block_unit gpio_chk u_gpio_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

FILE: dv/gpio_access_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// GPIO access checker
// Watches both stream ports of the GPIO register block. Every request taken on
// the input port is run through a local model of the register file, and the
// result it predicts is queued. Every result taken on the output port is
// compared field by field against the oldest queued prediction.
// -----------------------------------------------------------------------------
module gpio_access_checker
    import gpio_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // From bit 0: word_address[5:0], write_data[31:0], pin_levels, zero pad.
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // From bit 0: command.
    input  logic                   i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // From bit 0: read_data[31:0], pin_drive, pin_output_enable, pin_pull_up,
    // pin_pull_down, zero pad.
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int IN_DATA_LSB = 6;
    localparam int IN_LEV_LSB  = 6 + 32;

    typedef struct packed {
        logic [31:0] read_data;
        t_pins       drive;
        t_pins       out_en;
        t_pins       pull_up;
        t_pins       pull_down;
    } t_gpio_result;

    // Model of the register file.
    t_fsel fsel_mem  [NUM_PINS];
    t_pull pull_mode [NUM_PINS];
    t_pins drive_q;
    t_pull pud_q;

    t_gpio_result predicted_results [$];
    t_gpio_result got;
    t_gpio_result want;

    // Places a 32-bit bank word onto the pin bits it names.
    function automatic t_pins bank_pins(logic [31:0] d, logic bank);
        logic [63:0] w;
        w = bank ? {d, 32'b0} : {32'b0, d};
        return w[NUM_PINS-1:0];
    endfunction

    function automatic t_pins output_pins();
        t_pins m;
        m = '0;
        for (int p = 0; p < NUM_PINS; p++) begin
            m[p] = (fsel_mem[p] == FSEL_OUTPUT);
        end
        return m;
    endfunction

    // Performs one bus access on the model and returns what the block reports.
    task automatic perform_access(input logic cmd, input logic [5:0] a,
                                  input logic [31:0] d, input t_pins levels,
                                  output t_gpio_result r);
        logic [31:0] rd;
        logic [63:0] lv;
        t_pins       oe;
        t_pins       sel;
        int          p;
        rd = '0;
        if (cmd == CMD_WRITE) begin
            if (a < FSEL_WORDS) begin
                for (int i = 0; i < FSEL_SLOTS; i++) begin
                    p = int'(a) * FSEL_SLOTS + i;
                    if (p < NUM_PINS) fsel_mem[p] = d[FSEL_BITS*i +: FSEL_BITS];
                end
            end else if (a == ADDR_SET0 || a == ADDR_SET0 + 6'd1) begin
                drive_q = drive_q | bank_pins(d, a != ADDR_SET0);
            end else if (a == ADDR_CLR0 || a == ADDR_CLR0 + 6'd1) begin
                drive_q = drive_q & ~bank_pins(d, a != ADDR_CLR0);
            end else if (a == ADDR_PUD) begin
                pud_q = d[1:0];
            end else if (a == ADDR_PUDCLK0 || a == ADDR_PUDCLK0 + 6'd1) begin
                sel = bank_pins(d, a != ADDR_PUDCLK0);
                for (int q = 0; q < NUM_PINS; q++) begin
                    if (sel[q]) pull_mode[q] = pud_q;
                end
            end
        end else begin
            if (a < FSEL_WORDS) begin
                for (int i = 0; i < FSEL_SLOTS; i++) begin
                    p = int'(a) * FSEL_SLOTS + i;
                    if (p < NUM_PINS) rd[FSEL_BITS*i +: FSEL_BITS] = fsel_mem[p];
                end
            end else if (a == ADDR_LEV0 || a == ADDR_LEV1) begin
                // Output pins read back their latch, inputs the outside level.
                oe = output_pins();
                lv = 64'((drive_q & oe) | (levels & ~oe));
                rd = (a == ADDR_LEV1) ? lv[63:32] : lv[31:0];
            end else if (a == ADDR_PUD) begin
                rd = 32'(pud_q);
            end
        end
        r.read_data = rd;
        r.drive     = drive_q;
        r.out_en    = output_pins();
        for (int q = 0; q < NUM_PINS; q++) begin
            r.pull_up[q]   = (pull_mode[q] == PULL_UP);
            r.pull_down[q] = (pull_mode[q] == PULL_DOWN);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // Results are matched first, since a result always belongs to an older
    // request than the one taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PINS; p++) begin
                fsel_mem[p]  = '0;
                pull_mode[p] = '0;
            end
            drive_q = '0;
            pud_q   = '0;
            predicted_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.read_data = i_m_tdata[31:0];
                got.drive     = i_m_tdata[OUT_DRV_LSB +: NUM_PINS];
                got.out_en    = i_m_tdata[OUT_OE_LSB +: NUM_PINS];
                got.pull_up   = i_m_tdata[OUT_PU_LSB +: NUM_PINS];
                got.pull_down = i_m_tdata[OUT_PD_LSB +: NUM_PINS];
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with no request outstanding, actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("read_data", 64'(want.read_data), 64'(got.read_data));
                    check_field("pin_drive", 64'(want.drive), 64'(got.drive));
                    check_field("pin_output_enable", 64'(want.out_en), 64'(got.out_en));
                    check_field("pin_pull_up", 64'(want.pull_up), 64'(got.pull_up));
                    check_field("pin_pull_down", 64'(want.pull_down),
                                64'(got.pull_down));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                perform_access(i_s_tuser, i_s_tdata[5:0],
                               i_s_tdata[IN_DATA_LSB +: 32],
                               i_s_tdata[IN_LEV_LSB +: NUM_PINS], want);
                predicted_results.push_back(want);
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

FILE: dv/tb_gpio_register_block_unit.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// GPIO register block testbench
// Drives register accesses into the block, first a directed pass over every
// register and corner case, then random accesses with random gaps on both
// stream ports. The checker beside the block predicts and compares results.
// -----------------------------------------------------------------------------
module tb_gpio_register_block_unit;

    import gpio_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int ready_hold  = 0;
    bit quiet       = 1'b0;

    gpio_register_block_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gpio_access_checker u_access_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL gpio_register_block_unit");
            $finish;
        end
    end

    // Mostly no gap, some short ones and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result port back-pressure.
    always @(negedge i_clk) begin
        int g;
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(0, 5);
            end else begin
                m_axis_tready <= 1'b0;
                ready_hold = g - 1;
            end
        end
    end

    // Presents one request and holds it until it is taken.
    task automatic access(input logic cmd, input logic [5:0] addr,
                          input logic [31:0] data, input t_pins levels);
        logic [IN_TDATA_W-1:0] packed_req;
        packed_req = '0;
        packed_req[5:0] = addr;
        packed_req[6 +: 32] = data;
        packed_req[38 +: NUM_PINS] = levels;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= packed_req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        int g;
        g = quiet ? 0 : pick_gap();
        if (g > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_pins random_levels();
        return t_pins'({$urandom, $urandom});
    endfunction

    // Function select word with many slots set to output.
    function automatic logic [31:0] fsel_pattern();
        logic [31:0] d;
        d = $urandom;
        for (int i = 0; i < FSEL_SLOTS; i++) begin
            if ($urandom_range(0, 2) != 0) d[FSEL_BITS*i +: FSEL_BITS] = FSEL_OUTPUT;
        end
        return d;
    endfunction

    initial begin
        logic        cmd;
        logic [5:0]  addr;
        logic [31:0] data;
        int          kind;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass: reset values, all-ones and all-zero levels, every
        // register, pins beyond the bank, reserved pull code, unmapped words.
        access(CMD_READ,  6'd0, '0, '1);
        access(CMD_READ,  ADDR_LEV0, '0, '1);
        access(CMD_READ,  ADDR_LEV1, '1, '1);
        access(CMD_WRITE, 6'd0, '1, '0);
        access(CMD_READ,  6'd0, '0, '0);
        access(CMD_WRITE, 6'd5, 32'h0924_9249, '0);
        access(CMD_READ,  6'd5, '0, '0);
        access(CMD_WRITE, 6'd1, 32'h0924_9249, '0);
        access(CMD_WRITE, ADDR_SET0, '1, '0);
        access(CMD_WRITE, ADDR_SET0 + 6'd1, '1, '0);
        access(CMD_READ,  ADDR_LEV0, '0, '0);
        access(CMD_READ,  ADDR_SET0, '0, '1);
        access(CMD_WRITE, ADDR_CLR0, 32'h0000_ffff, '1);
        access(CMD_WRITE, ADDR_CLR0 + 6'd1, '1, '1);
        access(CMD_READ,  ADDR_CLR0 + 6'd1, '0, '1);
        access(CMD_READ,  ADDR_LEV1, '0, '0);
        access(CMD_WRITE, ADDR_PUD, '1, '0);
        access(CMD_READ,  ADDR_PUD, '0, '0);
        access(CMD_WRITE, ADDR_PUDCLK0, '1, '0);
        access(CMD_WRITE, ADDR_PUD, 32'(PULL_UP), '0);
        access(CMD_WRITE, ADDR_PUDCLK0 + 6'd1, '1, '0);
        access(CMD_WRITE, ADDR_PUD, 32'(PULL_DOWN), '0);
        access(CMD_WRITE, ADDR_PUDCLK0, 32'h0000_000f, '0);
        access(CMD_READ,  ADDR_PUDCLK0, '0, '1);
        access(CMD_WRITE, 6'd63, '1, '1);
        access(CMD_READ,  6'd63, '0, '1);
        access(CMD_WRITE, 6'd6, '1, '0);
        access(CMD_READ,  6'd6, '0, '1);

        // Random requests, mostly to mapped registers.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 200 && n < 280);
            kind = int'($urandom_range(0, 9));
            cmd  = 1'($urandom_range(0, 1));
            data = $urandom;
            case (kind)
                0, 1, 2: begin
                    addr = 6'($urandom_range(0, FSEL_WORDS - 1));
                    if ($urandom_range(0, 1)) data = fsel_pattern();
                end
                3: addr = ADDR_SET0 + 6'($urandom_range(0, 1));
                4: addr = ADDR_CLR0 + 6'($urandom_range(0, 1));
                5, 6: begin
                    addr = $urandom_range(0, 1) ? ADDR_LEV1 : ADDR_LEV0;
                    if ($urandom_range(0, 3) != 0) cmd = CMD_READ;
                end
                7: addr = ADDR_PUD;
                8: addr = ADDR_PUDCLK0 + 6'($urandom_range(0, 1));
                default: addr = 6'($urandom_range(0, 63));
            endcase
            access(cmd, addr, data, random_levels());
            sender_gap();
        end
        quiet = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("PASS gpio_register_block_unit");
        end else begin
            $display("FAIL gpio_register_block_unit");
        end
        $finish;
    end

endmodule
